FILE: hw/rtl/fir64_pkg.sv
package fir64_pkg;

	localparam int TAP_COUNT = 64;
	localparam int POS_W     = 6;
	localparam int SAMPLE_W  = 16;
	localparam int TAP_W     = 7;
	localparam int PROD_W    = SAMPLE_W + TAP_W;
	// |sum| <= 312 * 32768, fits 25 signed bits
	localparam int ACC_W     = 25;
	localparam int DIV_W     = 16;
	localparam int CNT_W     = POS_W + 1;

	// symmetric low-pass coefficients
	localparam logic signed [TAP_W-1:0] TAPS [TAP_COUNT] = '{
		  7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,
		  7'sd0,   7'sd0,  -7'sd1,  -7'sd2,  -7'sd2,  -7'sd3,  -7'sd3,  -7'sd2,
		 -7'sd1,   7'sd0,   7'sd0,   7'sd0,  -7'sd1,  -7'sd4,  -7'sd7, -7'sd10,
		-7'sd11, -7'sd10,  -7'sd6,   7'sd2,  7'sd11,  7'sd20,  7'sd28,  7'sd32,
		 7'sd32,  7'sd28,  7'sd20,  7'sd11,   7'sd2,  -7'sd6, -7'sd10, -7'sd11,
		-7'sd10,  -7'sd7,  -7'sd4,  -7'sd1,   7'sd0,   7'sd0,   7'sd0,  -7'sd1,
		 -7'sd2,  -7'sd3,  -7'sd3,  -7'sd2,  -7'sd2,  -7'sd1,   7'sd0,   7'sd0,
		  7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_second;
		logic signed [SAMPLE_W-1:0] sample_first;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0]   filtered_first;
		logic signed [SAMPLE_W-1:0]   filtered_second;
		logic signed [2*SAMPLE_W-1:0] packed_word;
	} out_word_t;

	typedef struct packed {
		logic                       en;
		logic [POS_W-1:0]           addr;
		logic signed [SAMPLE_W-1:0] data;
	} ring_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_MAC,
		ST_DRAIN,
		ST_DIV,
		ST_DONE
	} fsm_state_t;

endpackage

FILE: hw/rtl/fir64_ring.sv
module fir64_ring (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fir64_pkg::ring_wr_t                  wr,
	input  logic [fir64_pkg::POS_W-1:0]          raddr,
	output logic signed [fir64_pkg::SAMPLE_W-1:0] rdata
);
	import fir64_pkg::*;

	logic signed [SAMPLE_W-1:0] mem [TAP_COUNT];
	logic [TAP_COUNT-1:0]       vld_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic                       rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q <= mem[raddr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

FILE: hw/rtl/fir64_div.sv
module fir64_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [fir64_pkg::ACC_W-1:0]    dividend,
	input  logic [fir64_pkg::DIV_W-1:0]           divisor,
	output logic                                  done,
	output logic signed [fir64_pkg::SAMPLE_W-1:0] quotient
);
	import fir64_pkg::*;

	localparam int STEP_W = $clog2(ACC_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [DIV_W-1:0]  d_q;
	logic [DIV_W-1:0]  rem_q;
	logic [ACC_W-1:0]  quo_q;
	logic [DIV_W:0]    shifted;
	logic              fits;
	logic [ACC_W-1:0]  mag;
	logic [ACC_W-1:0]  quo_signed;

	assign mag     = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
	assign shifted = {rem_q, quo_q[ACC_W-1]};
	assign fits    = shifted >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ACC_W-1];
			d_q   <= (divisor == '0) ? DIV_W'(1) : divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_W'(shifted - {1'b0, d_q}) : shifted[DIV_W-1:0];
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

	assign quo_signed = neg_q ? ACC_W'(-quo_q) : quo_q;
	assign quotient   = quo_signed[SAMPLE_W-1:0];
	assign done       = done_q;

endmodule

FILE: hw/rtl/fir_64tap_packed_sample_filter_top.sv
// 64-tap FIR filter on packed sample pairs.
//
// Input channel (in_valid/in_ready/in_data): one word holds two signed 16-bit
// samples; sample_first (low half) is filtered before sample_second.
// Output channel (out_valid/out_ready/out_data): one word per input word with
// both filtered samples and their 32-bit packed form.
// Config channel (cfg_valid/cfg_ready/cfg_data): divisor for the tap sum,
// always ready; write it only while the filter is idle. Zero acts as one.
//
// Each sample costs one ring write, 64 reads of the sample ring (one read port,
// one multiply-accumulate per cycle), a pipeline drain and a 25-step serial
// divide with its done strobe. out_valid and in_ready rise together when a
// word's result is loaded into the output register. One word is worked on at a
// time; the next word is taken as soon as the previous result sits in the
// output register.
//
// Reset clears the ring (per-entry valid bits, so no clearing pass), the write
// position and sets the divisor to one. If the receiver stalls, the finished
// word waits in the output register and the next word's result is held back
// until that one is taken.
module fir_64tap_packed_sample_filter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  fir64_pkg::in_word_t             in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output fir64_pkg::out_word_t            out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fir64_pkg::DIV_W-1:0]     cfg_data
);
	import fir64_pkg::*;

	fsm_state_t state_q, state_d;

	logic [DIV_W-1:0]           divisor_q;
	in_word_t                   in_q;
	logic                       sel_q;        // 0: first sample, 1: second
	logic [POS_W-1:0]           wp_q;
	logic [CNT_W-1:0]           rd_cnt_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] f1_q;
	out_word_t                  out_q;
	logic                       out_valid_q;

	// MAC pipeline
	logic                       vld_s1;
	logic [POS_W-1:0]           tap_idx_s1;
	logic                       vld_s2;
	logic signed [PROD_W-1:0]   prod_s2;

	// FSM outputs
	logic accept_in;
	logic ring_we;
	logic rd_issue;
	logic div_start;
	logic out_load;

	ring_wr_t                   ring_wr;
	logic [POS_W-1:0]           raddr;
	logic signed [SAMPLE_W-1:0] rdata;
	logic                       div_done;
	logic signed [SAMPLE_W-1:0] quot;
	logic                       mac_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DIV_W'(1);
		end else if (cfg_valid) begin
			divisor_q <= cfg_data;
		end
	end

	assign mac_last = rd_cnt_q == CNT_W'(TAP_COUNT - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) begin
				state_d = ST_WRITE;
			end
			ST_WRITE: state_d = ST_MAC;
			ST_MAC:   if (mac_last) begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: if (!vld_s1 && !vld_s2) begin
				state_d = ST_DIV;
			end
			ST_DIV:   if (div_done) begin
				state_d = sel_q ? ST_DONE : ST_WRITE;
			end
			ST_DONE:  if (!out_valid_q || out_ready) begin
				state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_ready  = 1'b0;
		ring_we   = 1'b0;
		rd_issue  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready  = 1'b1;
			ST_WRITE: ring_we   = 1'b1;
			ST_MAC:   rd_issue  = 1'b1;
			ST_DRAIN: div_start = !vld_s1 && !vld_s2;
			ST_DIV:   ;
			ST_DONE:  out_load  = !out_valid_q || out_ready;
			default:  ;
		endcase
	end

	assign accept_in = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			wp_q        <= '0;
			rd_cnt_q    <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_issue;
			vld_s2  <= vld_s1;
			if (accept_in) begin
				sel_q <= 1'b0;
			end
			if (ring_we) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (div_done) begin
				wp_q  <= wp_q + 1'b1;
				sel_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// window starts one entry behind the sample just written
	assign raddr = POS_W'(wp_q - 1'b1 + rd_cnt_q[POS_W-1:0]);

	assign ring_wr.en   = ring_we;
	assign ring_wr.addr = wp_q;
	assign ring_wr.data = sel_q ? in_q.sample_second : in_q.sample_first;

	fir64_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ring_wr),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	always_ff @(posedge clk) begin
		if (accept_in) begin
			in_q <= in_data;
		end
		tap_idx_s1 <= rd_cnt_q[POS_W-1:0];
		prod_s2    <= PROD_W'(rdata) * PROD_W'(TAPS[tap_idx_s1]);
		if (ring_we) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
		if (div_done && !sel_q) begin
			f1_q <= quot;
		end
		if (out_load) begin
			out_q.filtered_first  <= f1_q;
			out_q.filtered_second <= quot;
			out_q.packed_word     <= {f1_q, {SAMPLE_W{1'b0}}}
			                         + {{SAMPLE_W{quot[SAMPLE_W-1]}}, quot};
		end
	end

	fir64_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

// Filter testbench. Words go in on the input channel. A local copy of the
// 64-tap filter works out the expected output word for each accepted word.
// The checker compares every output word against the oldest pending word.
module testbench;
	import fir64_pkg::*;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// DUT ports; every input is known from time zero
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_word_t          in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_word_t         out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [DIV_W-1:0]  cfg_data  = '0;

	fir_64tap_packed_sample_filter_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Local filter state: sample history, next write slot, divisor.
	// Mirrors what the DUT holds right after reset.
	logic signed [SAMPLE_W-1:0] hist_ring [TAP_COUNT];
	logic [POS_W-1:0]           hist_pos;
	logic [DIV_W-1:0]           div_reg;

	// output words still owed by the DUT, oldest first
	out_word_t pending_words [$];

	int mismatch_cnt = 0;

	// traffic shaping knobs, changed per phase by the test tasks
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// long receiver hold-off, counted down by the receiver process
	int hold_left      = 0;
	int stall_left     = 0;

	// Store one sample, run the taps over the ring, divide, advance.
	// The first tap lands on the slot just behind the one written.
	// SV integer division truncates toward zero, as the filter does.
	// A zero divisor acts as one.
	function automatic logic signed [SAMPLE_W-1:0] filter_sample(
		input logic signed [SAMPLE_W-1:0] s);
		int               acc;
		int               d;
		int               q;
		logic [POS_W-1:0] idx;
		hist_ring[hist_pos] = s;
		idx = hist_pos - 1'b1;
		acc = 0;
		for (int i = 0; i < TAP_COUNT; i++) begin
			acc += int'(hist_ring[idx]) * int'(TAPS[i]);
			idx = idx + 1'b1;
		end
		d = (div_reg == '0) ? 1 : int'(div_reg);
		q = acc / d;
		hist_pos = hist_pos + 1'b1;
		return q[SAMPLE_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// Offer one word, hold it until taken, then log its prediction.
	// Must be entered right after a rising edge. in_valid stays high on
	// return, so back-to-back words never drop valid within one step.
	task automatic send_word(input in_word_t w);
		int        gap;
		out_word_t r;
		gap = 0;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			// mostly short gaps, now and then one that spans a whole word
			gap = ($urandom_range(15) == 0) ? $urandom_range(250, 1) : $urandom_range(6, 1);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		r.filtered_first  = filter_sample(w.sample_first);
		r.filtered_second = filter_sample(w.sample_second);
		// first output in the upper half plus the sign-extended second, 32-bit wrap
		r.packed_word = {r.filtered_first, 16'h0000}
			+ {{SAMPLE_W{r.filtered_second[SAMPLE_W-1]}}, r.filtered_second};
		pending_words.push_back(r);
	endtask

	// Drop valid and wait until every owed output word has come back.
	// Each word gives exactly one output word, so the DUT is idle then.
	task automatic wait_idle();
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// Divisor write; only called from an idle DUT
	task automatic write_divisor(input logic [DIV_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		div_reg = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Samples: rails, zero, -1, small values, and full-range noise
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(9))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2:       return {{8{r[7]}}, r[7:0]};
			3:       return 16'h0000;
			4:       return 16'hffff;
			default: return r[15:0];
		endcase
	endfunction

	// Divisors: mostly small so outputs stay lively; also zero and the top value
	function automatic logic [DIV_W-1:0] rand_divisor();
		case ($urandom_range(7))
			0:       return '0;
			1:       return 16'hffff;
			2, 3:    return DIV_W'($urandom_range(16, 1));
			4, 5:    return DIV_W'($urandom_range(1024, 1));
			default: return DIV_W'($urandom);
		endcase
	endfunction

	// Receiver: random stalls per phase, occasional long stall, and the
	// pressure hold-off, which wins over everything else.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct) begin
			out_ready <= 1'b0;
			if ($urandom_range(31) == 0)
				stall_left = $urandom_range(250, 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Checker: every output word taken is matched to the oldest prediction
	always @(posedge clk) begin : check_out
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("word with none pending", out_data.packed_word, '0);
			end else begin
				want = pending_words.pop_front();
				if (out_data.filtered_first !== want.filtered_first)
					report_mismatch("filtered_first", 32'(out_data.filtered_first),
						32'(want.filtered_first));
				if (out_data.filtered_second !== want.filtered_second)
					report_mismatch("filtered_second", 32'(out_data.filtered_second),
						32'(want.filtered_second));
				if (out_data.packed_word !== want.packed_word)
					report_mismatch("packed_word", out_data.packed_word, want.packed_word);
			end
		end
	end

	// Words below are written {sample_second, sample_first}.
	// Starts from reset: cleared ring, divisor one.
	task automatic test_directed();
		// impulse: walks the taps through the ring
		send_word({16'h0000, 16'h0001});
		send_word({16'h0000, 16'h0000});
		send_word({16'h0000, 16'h0000});
		// rails and mixed signs, wrap of the 16-bit quotient
		send_word({16'h7fff, 16'h7fff});
		send_word({16'h8000, 16'h8000});
		send_word({16'h8000, 16'h7fff});
		send_word({16'h7fff, 16'h8000});
		send_word({16'hffff, 16'hffff});
		send_word({16'haaaa, 16'h5555});
		send_word({16'h5555, 16'haaaa});
		// run at the positive rail; half the ring is written by its end
		repeat (6) send_word({16'h7fff, 16'h7fff});
		wait_idle();
		// zero divisor behaves as one
		write_divisor('0);
		send_word({16'h8000, 16'h7fff});
		send_word({16'h0001, 16'hffff});
		wait_idle();
		// largest divisor: quotients near zero
		write_divisor(16'hffff);
		send_word({16'h7fff, 16'h8000});
		send_word({16'h8000, 16'h8000});
		wait_idle();
		// even divisor with odd negative sums: truncation toward zero
		write_divisor(16'd2);
		send_word({16'hffff, 16'hffff});
		send_word({16'h0001, 16'hfffd});
		send_word({16'hfffb, 16'h0003});
		wait_idle();
	endtask

	// Random words in three blocks, each under a fresh divisor
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int n);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int b = 0; b < 3; b++) begin
			wait_idle();
			write_divisor(rand_divisor());
			for (int k = 0; k < n; k++)
				send_word({rand_sample(), rand_sample()});
		end
		wait_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver holds off for a long stretch while words keep coming:
	// the output register fills, the next result is held back and
	// in_ready drops until the hold ends.
	task automatic test_backpressure();
		wait_idle();
		write_divisor(16'd3);
		hold_left = 1500;
		repeat (12) send_word({rand_sample(), rand_sample()});
		wait_idle();
	endtask

	initial begin : main
		for (int i = 0; i < TAP_COUNT; i++)
			hist_ring[i] = '0;
		hist_pos = '0;
		div_reg  = 16'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(0, 0, 120);
		test_random_traffic(67, 0, 120);
		test_random_traffic(0, 67, 120);
		test_random_traffic(31, 31, 120);
		test_backpressure();

		// idle wait to catch stray output words
		repeat (400) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// run limit, several times the slowest legal run
	initial begin
		#40ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
